// ----- rtl/dpb_pkg.sv -----
// shared types, widths and constants of the depth pixel back-projection core
package dpb_pkg;

  localparam int IDX_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int COORD_W = 24;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // fixed-point datapath widths
  localparam int FRAC_W = 4;                  // q12.4 fraction bits
  localparam int OFF_W  = CFG_W;              // |index*16 - center|
  localparam int MAG_W  = OFF_W + DEPTH_W;    // offset * depth
  localparam int NUM_W  = MAG_W + 1;          // 2*mag + f
  localparam int DEN_W  = CFG_W + 1;          // 2*f
  localparam int QUO_W  = COORD_W;            // quotient bits resolved
  localparam int SHD_W  = DEN_W + QUO_W;      // shifted divisor

  // subsample reciprocal
  localparam int MOD_SHIFT = 16;

  // input register, offset, multiply, numerator, divider, output register
  localparam int PIPE_LATENCY = 5 + QUO_W;

  localparam int SUBSAMPLE_STEP_DEF = 3;

  localparam logic [CFG_W-1:0] FOCAL_X_RST   = 16'd8192;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST   = 16'd8192;
  localparam logic [CFG_W-1:0] CENTER_X_RST  = 16'd5120;
  localparam logic [CFG_W-1:0] CENTER_Y_RST  = 16'd3840;
  localparam logic [CFG_W-1:0] MIN_DEPTH_RST = 16'd10;
  localparam logic [CFG_W-1:0] MAX_DEPTH_RST = 16'd5000;

  localparam logic [COORD_W-1:0] SAT_POS     = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] SAT_NEG_MAG = 24'h800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_CENTER_X  = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_MIN_DEPTH = 3'd4,
    CFG_MAX_DEPTH = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_row;
    logic [IDX_W-1:0]   pixel_col;
    logic [DEPTH_W-1:0] depth_mm;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic [COLOR_W-1:0]        out_blue;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_red;
  } point_t;

  // side information that rides along the divider
  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
  } div_tag_t;

endpackage

// ----- rtl/dpb_div.sv -----
// pipelined restoring divider, two lanes in lockstep, one quotient bit per stage
module dpb_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_vld,
  input  logic [1:0][dpb_pkg::NUM_W-1:0]         num,
  input  logic [1:0][dpb_pkg::DEN_W-1:0]         den,
  input  dpb_pkg::div_tag_t                      req_tag,
  output logic                                   res_vld,
  output logic [1:0][dpb_pkg::QUO_W-1:0]         quo,
  output dpb_pkg::div_tag_t                      res_tag
);

  localparam int NUM_W = dpb_pkg::NUM_W;
  localparam int DEN_W = dpb_pkg::DEN_W;
  localparam int QUO_W = dpb_pkg::QUO_W;
  localparam int SHD_W = dpb_pkg::SHD_W;

  logic                         vld   [QUO_W+1];
  logic [1:0][QUO_W-1:0]        quo_q [QUO_W+1];
  dpb_pkg::div_tag_t            tag_q [QUO_W+1];
  logic [1:0][NUM_W-1:0]        rem_q [QUO_W];
  logic [1:0][DEN_W-1:0]        den_q [QUO_W];

  assign vld[0]   = req_vld;
  assign quo_q[0] = '0;
  assign tag_q[0] = req_tag;
  assign rem_q[0] = num;
  assign den_q[0] = den;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BIT = QUO_W - 1 - s;

    logic [1:0][SHD_W-1:0] sh;
    logic [1:0][SHD_W-1:0] ext;
    logic [1:0][SHD_W-1:0] diff;
    logic [1:0]            ge;
    logic [1:0][QUO_W-1:0] quo_next;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l]   = SHD_W'(den_q[s][l]) << BIT;
        ext[l]  = SHD_W'(rem_q[s][l]);
        ge[l]   = ext[l] >= sh[l];
        diff[l] = ext[l] - sh[l];
        quo_next[l] = quo_q[s][l];
        quo_next[l][BIT] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      quo_q[s+1] <= quo_next;
      tag_q[s+1] <= tag_q[s];
    end

    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[s+1][l] <= ge[l] ? diff[l][NUM_W-1:0] : rem_q[s][l];
        end
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign res_vld = vld[QUO_W];
  assign quo     = quo_q[QUO_W];
  assign res_tag = tag_q[QUO_W];

endmodule

// ----- rtl/depth_pixel_backprojection_core.sv -----
// top level of the depth pixel back-projection core
//
// usage
//   a request (one rgb-d pixel on pixel) is taken at each rising edge with
//   start high and busy low. busy is low at all times outside reset, so a
//   new pixel may be presented every cycle
//   pixels whose row or column is not a multiple of SUBSAMPLE_STEP, or whose
//   depth lies outside min_depth_mm..max_depth_mm, give no result
//   a kept pixel gives one point on point, marked by done for one cycle,
//   after the input, offset, multiply, numerator, divider and output
//   registers, with one divider stage per bit of the 24-bit quotient
//   throughput is one pixel per cycle; the receiver cannot stall and takes
//   every result as it appears. intrinsics and depth limits are written on
//   cfg_we/cfg_index/cfg_data by the user only while no request is in
//   flight, not enforced by the core; indices past the last register are
//   ignored. reset (rst, synchronous) clears every in-flight request, drops
//   done and loads the default intrinsics; busy is high while rst is high
module depth_pixel_backprojection_core #(
  parameter int SUBSAMPLE_STEP = dpb_pkg::SUBSAMPLE_STEP_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dpb_pkg::pixel_t                pixel,
  output logic                           done,
  output dpb_pkg::point_t                point,
  input  logic                           cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_W-1:0]      cfg_data
);

  localparam int IDX_W   = dpb_pkg::IDX_W;
  localparam int CFG_W   = dpb_pkg::CFG_W;
  localparam int OFF_W   = dpb_pkg::OFF_W;
  localparam int MAG_W   = dpb_pkg::MAG_W;
  localparam int NUM_W   = dpb_pkg::NUM_W;
  localparam int DEN_W   = dpb_pkg::DEN_W;
  localparam int QUO_W   = dpb_pkg::QUO_W;
  localparam int SHD_W   = dpb_pkg::SHD_W;
  localparam int COORD_W = dpb_pkg::COORD_W;
  localparam int FRAC_W  = dpb_pkg::FRAC_W;

  // subsample test: q = (idx * recip) >> shift is the true quotient or one
  // below, so the estimated remainder is either 0 or step when idx divides
  localparam int MOD_SHIFT = dpb_pkg::MOD_SHIFT;
  localparam int RECIP_W   = MOD_SHIFT + 1;
  localparam int PROD_W    = IDX_W + RECIP_W;
  localparam int STEP_W    = $clog2(SUBSAMPLE_STEP + 1);
  localparam int RM_W      = IDX_W + STEP_W;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((1 << MOD_SHIFT) / SUBSAMPLE_STEP);
  localparam logic [RM_W-1:0]    STEP_V = RM_W'(SUBSAMPLE_STEP);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] focal_x, focal_y, center_x, center_y, min_depth, max_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x   <= dpb_pkg::FOCAL_X_RST;
      focal_y   <= dpb_pkg::FOCAL_Y_RST;
      center_x  <= dpb_pkg::CENTER_X_RST;
      center_y  <= dpb_pkg::CENTER_Y_RST;
      min_depth <= dpb_pkg::MIN_DEPTH_RST;
      max_depth <= dpb_pkg::MAX_DEPTH_RST;
    end else if (cfg_we) begin
      case (dpb_pkg::cfg_idx_t'(cfg_index))
        dpb_pkg::CFG_FOCAL_X:   focal_x   <= cfg_data;
        dpb_pkg::CFG_FOCAL_Y:   focal_y   <= cfg_data;
        dpb_pkg::CFG_CENTER_X:  center_x  <= cfg_data;
        dpb_pkg::CFG_CENTER_Y:  center_y  <= cfg_data;
        dpb_pkg::CFG_MIN_DEPTH: min_depth <= cfg_data;
        dpb_pkg::CFG_MAX_DEPTH: max_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero focal length counts as one lsb
  logic [CFG_W-1:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x == '0) ? CFG_W'(1) : focal_x;
  assign fy_eff = (focal_y == '0) ? CFG_W'(1) : focal_y;

  // the pipeline never stalls; only reset holds requests off
  assign busy = rst;

  // ---------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------
  logic            s1_vld;
  dpb_pkg::pixel_t s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_pix <= pixel;
  end

  // ---------------------------------------------------------------------
  // stage 2: principal point offsets, depth window, subsample quotients
  // ---------------------------------------------------------------------
  logic [OFF_W-1:0]  col_q4, row_q4;
  logic              neg_x, neg_y;
  logic [PROD_W-1:0] prod_row, prod_col;

  assign col_q4   = {s1_pix.pixel_col, FRAC_W'(0)};
  assign row_q4   = {s1_pix.pixel_row, FRAC_W'(0)};
  assign neg_x    = col_q4 < center_x;
  assign neg_y    = row_q4 < center_y;
  assign prod_row = PROD_W'(s1_pix.pixel_row) * PROD_W'(RECIP);
  assign prod_col = PROD_W'(s1_pix.pixel_col) * PROD_W'(RECIP);

  logic             s2_vld;
  dpb_pkg::pixel_t  s2_pix;
  logic             s2_in_range;
  logic             s2_neg_x, s2_neg_y;
  logic [OFF_W-1:0] s2_off_x, s2_off_y;
  logic [IDX_W-1:0] s2_q_row, s2_q_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_pix      <= s1_pix;
    s2_in_range <= (s1_pix.depth_mm >= min_depth) && (s1_pix.depth_mm <= max_depth);
    s2_neg_x    <= neg_x;
    s2_neg_y    <= neg_y;
    s2_off_x    <= neg_x ? center_x - col_q4 : col_q4 - center_x;
    s2_off_y    <= neg_y ? center_y - row_q4 : row_q4 - center_y;
    s2_q_row    <= prod_row[MOD_SHIFT +: IDX_W];
    s2_q_col    <= prod_col[MOD_SHIFT +: IDX_W];
  end

  // ---------------------------------------------------------------------
  // stage 3: keep decision, offset times depth
  // ---------------------------------------------------------------------
  logic [RM_W-1:0] rem_row, rem_col;
  logic            row_ok, col_ok, keep;

  assign rem_row = RM_W'(s2_pix.pixel_row) - RM_W'(s2_q_row) * STEP_V;
  assign rem_col = RM_W'(s2_pix.pixel_col) - RM_W'(s2_q_col) * STEP_V;
  assign row_ok  = (rem_row == '0) || (rem_row == STEP_V);
  assign col_ok  = (rem_col == '0) || (rem_col == STEP_V);
  assign keep    = s2_in_range && row_ok && col_ok;

  logic              s3_vld;
  dpb_pkg::div_tag_t s3_tag;
  logic [MAG_W-1:0]  s3_mag_x, s3_mag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      // rejected pixels leave the pipeline here
      s3_vld <= s2_vld && keep;
    end
    s3_tag.depth_mm <= s2_pix.depth_mm;
    s3_tag.blue     <= s2_pix.blue;
    s3_tag.green    <= s2_pix.green;
    s3_tag.red      <= s2_pix.red;
    s3_tag.neg_x    <= s2_neg_x;
    s3_tag.neg_y    <= s2_neg_y;
    s3_tag.ovf_x    <= 1'b0;
    s3_tag.ovf_y    <= 1'b0;
    s3_mag_x        <= MAG_W'(s2_off_x) * MAG_W'(s2_pix.depth_mm);
    s3_mag_y        <= MAG_W'(s2_off_y) * MAG_W'(s2_pix.depth_mm);
  end

  // ---------------------------------------------------------------------
  // stage 4: rounding numerator (2*mag + f) over divisor 2*f
  // ---------------------------------------------------------------------
  logic                   s4_vld;
  dpb_pkg::div_tag_t      s4_tag;
  logic [1:0][NUM_W-1:0]  s4_num;
  logic [1:0][DEN_W-1:0]  s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_tag    <= s3_tag;
    s4_num[0] <= {s3_mag_x, 1'b0} + NUM_W'(fx_eff);
    s4_num[1] <= {s3_mag_y, 1'b0} + NUM_W'(fy_eff);
    s4_den[0] <= {fx_eff, 1'b0};
    s4_den[1] <= {fy_eff, 1'b0};
  end

  // quotients of 2^24 and above saturate either way; the divider only
  // resolves the low 24 bits
  dpb_pkg::div_tag_t div_tag;

  always_comb begin
    div_tag       = s4_tag;
    div_tag.ovf_x = SHD_W'(s4_num[0]) >= {s4_den[0], QUO_W'(0)};
    div_tag.ovf_y = SHD_W'(s4_num[1]) >= {s4_den[1], QUO_W'(0)};
  end

  // ---------------------------------------------------------------------
  // divider pipeline, one quotient bit per stage
  // ---------------------------------------------------------------------
  logic                   d_vld;
  logic [1:0][QUO_W-1:0]  d_quo;
  dpb_pkg::div_tag_t      d_tag;

  dpb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req_vld (s4_vld),
    .num     (s4_num),
    .den     (s4_den),
    .req_tag (div_tag),
    .res_vld (d_vld),
    .quo     (d_quo),
    .res_tag (d_tag)
  );

  // ---------------------------------------------------------------------
  // saturate, restore sign, output register
  // ---------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] sat_axis(
    input logic [QUO_W-1:0] q,
    input logic             neg,
    input logic             ovf
  );
    logic [COORD_W-1:0] mag;
    if (neg) begin
      mag = (ovf || q > dpb_pkg::SAT_NEG_MAG) ? dpb_pkg::SAT_NEG_MAG : q;
      return COORD_W'(0) - mag;
    end
    return (ovf || q > dpb_pkg::SAT_POS) ? dpb_pkg::SAT_POS : q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
    point.point_x   <= sat_axis(d_quo[0], d_tag.neg_x, d_tag.ovf_x);
    point.point_y   <= sat_axis(d_quo[1], d_tag.neg_y, d_tag.ovf_y);
    point.point_z   <= d_tag.depth_mm;
    point.out_blue  <= d_tag.blue;
    point.out_green <= d_tag.green;
    point.out_red   <= d_tag.red;
  end

endmodule

// ----- rtl/dpb_checker.sv -----
// port-level assertions for the back-projection core and their bind
module dpb_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input dpb_pkg::pixel_t pixel,
  input logic            done,
  input dpb_pkg::point_t point
);

  localparam int LAT = dpb_pkg::PIPE_LATENCY;

  // no request is taken while in reset
  a_busy_in_reset: assert property (@(posedge clk) rst |-> busy)
    else $error("busy low during reset");

  // reset flushes every request in flight
  a_flush: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result shown right after reset");

  // every result comes from a request taken a fixed latency earlier
  a_req_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // depth and colour pass through unchanged with the result
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    done |-> (point.point_z == $past(pixel.depth_mm, LAT)) &&
             (point.out_blue == $past(pixel.blue, LAT)) &&
             (point.out_green == $past(pixel.green, LAT)) &&
             (point.out_red == $past(pixel.red, LAT)))
    else $error("pass-through fields mismatch");

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .pixel (pixel),
  .done  (done),
  .point (point)
);
